@@ hdl/cdq_pkg.sv @@
// Shared types and constants for the circular deque.
`default_nettype none

package cdq_pkg;

   // Field widths of the request and response beats.
   localparam int DATA_W = 32;
   localparam int CNT_W  = 11;
   localparam int MODE_W = 3;

   // Default ring depth and the capacity loaded at reset.
   localparam int DEPTH_DEFAULT = 1024;
   localparam int CAP_RESET     = 1024;

   // Operation codes carried in the mode field.
   typedef enum logic [MODE_W-1:0] {
      MODE_INS_FRONT = 3'd0,
      MODE_INS_REAR  = 3'd1,
      MODE_DEL_FRONT = 3'd2,
      MODE_DEL_REAR  = 3'd3,
      MODE_RD_FRONT  = 3'd4,
      MODE_RD_REAR   = 3'd5
   } mode_type;

   // Response fields that travel from the access stage to the output register.
   typedef struct packed {
      logic             ok;
      logic             use_ram;
      logic             neg_one;
      logic [CNT_W-1:0] count;
      logic             is_empty;
      logic             is_full;
   } stage_type;

endpackage

`default_nettype wire

@@ hdl/cdq_req_if.sv @@
// Request channel: one operation per beat.
`default_nettype none

interface cdq_req_if
   import cdq_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic signed [DATA_W-1:0] data_in;

   modport source (output valid, output mode, output data_in, input ready);
   modport sink   (input valid, input mode, input data_in, output ready);
endinterface

`default_nettype wire

@@ hdl/cdq_rsp_if.sv @@
// Response channel: one result per beat.
`default_nettype none

interface cdq_rsp_if
   import cdq_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic                     ok;
   logic signed [DATA_W-1:0] data_out;
   logic [CNT_W-1:0]         count;
   logic                     is_empty;
   logic                     is_full;

   modport source (output valid, output ok, output data_out, output count,
                   output is_empty, output is_full, input ready);
   modport sink   (input valid, input ok, input data_out, input count,
                   input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

@@ hdl/cdq_ram.sv @@
// Generic single-port RAM with registered read data.
`default_nettype none

module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write on enable with write strobe; otherwise read, and hold the data
   // until the next read.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end

endmodule

`default_nettype wire

@@ hdl/circular_deque.sv @@
// Top level of the circular deque: pointers, occupancy and response pipeline.
`default_nettype none

// The deque holds signed 32-bit words in a ring of DEPTH memory slots, of
// which the first "capacity" slots are used; writing csr_wdata with csr_we
// sets the capacity (0 is taken as 1, values above DEPTH as DEPTH) and empties
// the deque. Each request beat carries one operation and yields exactly one
// response beat. A request is taken every cycle while the response side keeps
// up: the operation reads or writes the single ring RAM port in the cycle it
// is accepted, the word read appears in the next cycle, and the response is
// registered in the output register after that. The ring contents are not
// cleared at reset; only slots holding stored words are ever read.
module circular_deque
   import cdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   cdq_req_if.sink               req_ch,
   cdq_rsp_if.source             rsp_ch,
   input  wire logic             csr_we,
   input  wire logic [CNT_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
   localparam int CAP_INIT = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] occ_ff, occ_in;

   logic      s1_valid_ff;
   stage_type s1_ff, s1_in;
   logic      out_valid_ff;
   logic      out_ok_ff;
   logic [DATA_W-1:0] out_data_ff, out_data_in;
   logic [CNT_W-1:0]  out_count_ff;
   logic      out_empty_ff;
   logic      out_full_ff;

   logic             accept;
   logic             s1_move;
   logic             ram_en;
   logic             ram_we;
   logic [IDX_W-1:0] ram_addr;
   logic [DATA_W-1:0] ram_rdata;
   logic             full;
   logic             empty;
   logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
   logic [CNT_W-1:0] cap_wr;

   // Wrap-around neighbors of the two pointers within the capacity.
   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
      logic [CMP_W-1:0] nxt;
      nxt = CMP_W'(idx) + CMP_W'(1);
      return (nxt >= CMP_W'(cap)) ? '0 : nxt[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] last;
      last = cap - CNT_W'(1);
      return (idx == '0) ? IDX_W'(last) : idx - IDX_W'(1);
   endfunction

   assign head_inc = wrap_inc(head_ff, cap_ff);
   assign head_dec = wrap_dec(head_ff, cap_ff);
   assign tail_inc = wrap_inc(tail_ff, cap_ff);
   assign tail_dec = wrap_dec(tail_ff, cap_ff);

   assign full  = (occ_ff >= cap_ff);
   assign empty = (occ_ff == '0);

   // The access stage moves on when the output register is free or drained.
   assign s1_move      = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_move;
   assign accept       = req_ch.valid && req_ch.ready;

   // Saturate a written capacity into 1..DEPTH.
   always_comb begin
      cap_wr = csr_wdata;
      if (csr_wdata == '0) begin
         cap_wr = CNT_W'(1);
      end else if (32'(csr_wdata) > 32'(DEPTH)) begin
         cap_wr = CNT_W'(DEPTH);
      end
   end

   // Decode the operation: pointer updates, RAM access and status fields.
   always_comb begin
      cap_in   = cap_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      occ_in   = occ_ff;
      ram_en   = 1'b0;
      ram_we   = 1'b0;
      ram_addr = head_ff;
      s1_in    = '0;

      case (mode_type'(req_ch.mode))
         MODE_INS_FRONT: begin
            if (!full) begin
               head_in  = head_dec;
               occ_in   = occ_ff + CNT_W'(1);
               ram_en   = 1'b1;
               ram_we   = 1'b1;
               ram_addr = head_dec;
               s1_in.ok = 1'b1;
            end
         end
         MODE_INS_REAR: begin
            if (!full) begin
               tail_in  = tail_inc;
               occ_in   = occ_ff + CNT_W'(1);
               ram_en   = 1'b1;
               ram_we   = 1'b1;
               ram_addr = tail_ff;
               s1_in.ok = 1'b1;
            end
         end
         MODE_DEL_FRONT: begin
            if (!empty) begin
               head_in  = head_inc;
               occ_in   = occ_ff - CNT_W'(1);
               s1_in.ok = 1'b1;
            end
         end
         MODE_DEL_REAR: begin
            if (!empty) begin
               tail_in  = tail_dec;
               occ_in   = occ_ff - CNT_W'(1);
               s1_in.ok = 1'b1;
            end
         end
         MODE_RD_FRONT: begin
            if (empty) begin
               s1_in.neg_one = 1'b1;
            end else begin
               ram_en        = 1'b1;
               ram_addr      = head_ff;
               s1_in.ok      = 1'b1;
               s1_in.use_ram = 1'b1;
            end
         end
         MODE_RD_REAR: begin
            if (empty) begin
               s1_in.neg_one = 1'b1;
            end else begin
               ram_en        = 1'b1;
               ram_addr      = tail_dec;
               s1_in.ok      = 1'b1;
               s1_in.use_ram = 1'b1;
            end
         end
         default: begin
            s1_in.ok = 1'b0;
         end
      endcase

      s1_in.count    = occ_in;
      s1_in.is_empty = (occ_in == '0);
      s1_in.is_full  = (occ_in == cap_ff);

      // Only an accepted beat touches the RAM and the pointers.
      if (!accept) begin
         head_in = head_ff;
         tail_in = tail_ff;
         occ_in  = occ_ff;
         ram_en  = 1'b0;
      end

      // A capacity write empties the deque.
      if (csr_we) begin
         cap_in  = cap_wr;
         head_in = '0;
         tail_in = '0;
         occ_in  = '0;
      end
   end

   cdq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_ch.data_in),
      .rdata (ram_rdata)
   );

   // Pointer, occupancy and capacity registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= CNT_W'(CAP_INIT);
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
      end else begin
         cap_ff  <= cap_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
      end
   end

   // Access stage: status waits here while the RAM read completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // Pick the word for the response: RAM data, all ones, or zero.
   always_comb begin
      if (s1_ff.use_ram) begin
         out_data_in = ram_rdata;
      end else if (s1_ff.neg_one) begin
         out_data_in = '1;
      end else begin
         out_data_in = '0;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_ok_ff    <= s1_ff.ok;
         out_data_ff  <= out_data_in;
         out_count_ff <= s1_ff.count;
         out_empty_ff <= s1_ff.is_empty;
         out_full_ff  <= s1_ff.is_full;
      end
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.ok       = out_ok_ff;
   assign rsp_ch.data_out = out_data_ff;
   assign rsp_ch.count    = out_count_ff;
   assign rsp_ch.is_empty = out_empty_ff;
   assign rsp_ch.is_full  = out_full_ff;

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the circular deque: directed and random operation streams.
`timescale 1ns / 1ps

module testbench;
   import cdq_pkg::*;

   // Codes in the mode field that name no operation.
   localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

   // Corner words for the data field.
   localparam logic [DATA_W-1:0] WORD_MAX  = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] WORD_MIN  = 32'h8000_0000;
   localparam logic [DATA_W-1:0] WORD_ZERO = 32'h0000_0000;
   localparam logic [DATA_W-1:0] WORD_ONES = 32'hffff_ffff;

   localparam int MAX_PRINTED = 40;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [DATA_W-1:0] word;
   } deque_op_type;

   typedef struct packed {
      logic              ok;
      logic [DATA_W-1:0] data_out;
      logic [CNT_W-1:0]  count;
      logic              is_empty;
      logic              is_full;
   } deque_answer_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we;
   logic [CNT_W-1:0] csr_wdata;

   cdq_req_if req_ch ();
   cdq_rsp_if rsp_ch ();

   circular_deque dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // Operations waiting to be sent and answers waiting to arrive.
   deque_op_type     queued_ops[$];
   deque_answer_type pending_answers[$];

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned error_count   = 0;
   int unsigned rsp_beats     = 0;

   // Shadow copy of the deque.
   logic [DATA_W-1:0] ring_words [DEPTH_DEFAULT];
   int unsigned       front_slot;
   int unsigned       back_slot;
   int unsigned       stored_count;
   int unsigned       slots_in_use;

   task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                                input logic [DATA_W-1:0] want);
      if (error_count < MAX_PRINTED)
         $display("MISMATCH at response beat %0d, %s: got %h, expected %h",
                  rsp_beats, what, got, want);
      error_count++;
   endtask

   function automatic int unsigned step_up(input int unsigned i);
      return (i + 1 >= slots_in_use) ? 0 : i + 1;
   endfunction

   function automatic int unsigned step_down(input int unsigned i);
      return (i == 0 || i > slots_in_use) ? slots_in_use - 1 : i - 1;
   endfunction

   function automatic void clear_deque();
      front_slot   = 0;
      back_slot    = 0;
      stored_count = 0;
   endfunction

   // A capacity write saturates into 1..DEPTH and always empties the deque.
   function automatic void load_capacity(input logic [CNT_W-1:0] value);
      int unsigned v;
      v = 32'(value);
      if (v == 0) v = 1;
      if (v > DEPTH_DEFAULT) v = DEPTH_DEFAULT;
      slots_in_use = v;
      clear_deque();
   endfunction

   // Applies one operation to the shadow deque and returns the answer it must give.
   function automatic deque_answer_type predict_deque_op(input logic [MODE_W-1:0] mode,
                                                         input logic [DATA_W-1:0] word);
      deque_answer_type ans;
      bit               at_full;
      bit               at_empty;
      ans      = '0;
      at_full  = stored_count >= slots_in_use;
      at_empty = stored_count == 0;
      case (mode)
         MODE_INS_FRONT: begin
            if (!at_full) begin
               front_slot = step_down(front_slot);
               ring_words[front_slot] = word;
               stored_count++;
               ans.ok = 1'b1;
            end
         end
         MODE_INS_REAR: begin
            if (!at_full) begin
               ring_words[back_slot] = word;
               back_slot = step_up(back_slot);
               stored_count++;
               ans.ok = 1'b1;
            end
         end
         MODE_DEL_FRONT: begin
            if (!at_empty) begin
               front_slot = step_up(front_slot);
               stored_count--;
               ans.ok = 1'b1;
            end
         end
         MODE_DEL_REAR: begin
            if (!at_empty) begin
               back_slot = step_down(back_slot);
               stored_count--;
               ans.ok = 1'b1;
            end
         end
         MODE_RD_FRONT, MODE_RD_REAR: begin
            if (at_empty) begin
               ans.data_out = WORD_ONES;
            end else begin
               ans.data_out = (mode == MODE_RD_FRONT) ? ring_words[front_slot]
                                                      : ring_words[step_down(back_slot)];
               ans.ok = 1'b1;
            end
         end
         default: ;
      endcase
      ans.count    = stored_count[CNT_W-1:0];
      ans.is_empty = stored_count == 0;
      ans.is_full  = stored_count == slots_in_use;
      return ans;
   endfunction

   // Request driver: predicts each accepted beat and presents the next one.
   always @(posedge clock) begin
      deque_op_type next;
      if (reset) begin
         slots_in_use = CAP_RESET;
         clear_deque();
         req_ch.valid <= 1'b0;
      end else begin
         if (csr_we)
            load_capacity(csr_wdata);
         if (req_ch.valid && req_ch.ready)
            pending_answers.push_back(predict_deque_op(req_ch.mode, req_ch.data_in));
         if (!req_ch.valid || req_ch.ready) begin
            if (queued_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next = queued_ops.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.mode    <= next.mode;
               req_ch.data_in <= next.word;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each beat against the oldest answer and stalls at random.
   always @(posedge clock) begin
      deque_answer_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_answers.size() == 0) begin
               flag_mismatch("beat with no request", rsp_ch.data_out, '0);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_ch.ok !== want.ok)
                  flag_mismatch("ok", DATA_W'(rsp_ch.ok), DATA_W'(want.ok));
               if (rsp_ch.data_out !== want.data_out)
                  flag_mismatch("data_out", rsp_ch.data_out, want.data_out);
               if (rsp_ch.count !== want.count)
                  flag_mismatch("count", DATA_W'(rsp_ch.count), DATA_W'(want.count));
               if (rsp_ch.is_empty !== want.is_empty)
                  flag_mismatch("is_empty", DATA_W'(rsp_ch.is_empty),
                                DATA_W'(want.is_empty));
               if (rsp_ch.is_full !== want.is_full)
                  flag_mismatch("is_full", DATA_W'(rsp_ch.is_full),
                                DATA_W'(want.is_full));
            end
            rsp_beats++;
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic push_op(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] word);
      deque_op_type op;
      op.mode = mode;
      op.word = word;
      queued_ops.push_back(op);
   endtask

   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(15))
         0:       return WORD_MAX;
         1:       return WORD_MIN;
         2:       return WORD_ZERO;
         3:       return WORD_ONES;
         default: return $urandom();
      endcase
   endfunction

   // Rotates through the idling patterns, one per phase.
   task automatic set_idling(input int unsigned phase);
      case (phase % 4)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 69; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 69; end
         default: begin send_idle_pct = 21; rsp_stall_pct = 21; end
      endcase
   endtask

   // Holds until every queued beat has been sent and answered.
   task automatic wait_drained();
      do @(negedge clock);
      while (queued_ops.size() != 0 || req_ch.valid || pending_answers.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CNT_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Runs that lean toward growing or shrinking, so small rings hit full and empty often.
   task automatic queue_random_ops(input int n);
      bit          grow;
      int unsigned roll;
      grow = 1'b1;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(15) == 0) grow = !grow;
         roll = $urandom_range(99);
         if (roll < 3)
            push_op($urandom_range(1) ? MODE_SPARE_6 : MODE_SPARE_7, pick_word());
         else if (roll < 23)
            push_op($urandom_range(1) ? MODE_RD_FRONT : MODE_RD_REAR, pick_word());
         else if ($urandom_range(99) < (grow ? 75 : 25))
            push_op($urandom_range(1) ? MODE_INS_FRONT : MODE_INS_REAR, pick_word());
         else
            push_op($urandom_range(1) ? MODE_DEL_FRONT : MODE_DEL_REAR, pick_word());
      end
   endtask

   initial begin
      logic [CNT_W-1:0] cap_value;
      req_ch.valid   = 1'b0;
      req_ch.mode    = MODE_INS_FRONT;
      req_ch.data_in = '0;
      rsp_ch.ready   = 1'b0;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset capacity: empty-deque failures, spare codes, corner words at both ends.
      set_idling(0);
      push_op(MODE_RD_FRONT, WORD_MAX);
      push_op(MODE_RD_REAR, WORD_MIN);
      push_op(MODE_DEL_FRONT, WORD_ZERO);
      push_op(MODE_DEL_REAR, WORD_ONES);
      push_op(MODE_SPARE_6, WORD_ONES);
      push_op(MODE_SPARE_7, WORD_MAX);
      push_op(MODE_INS_FRONT, WORD_MAX);
      push_op(MODE_INS_REAR, WORD_MIN);
      push_op(MODE_INS_FRONT, WORD_ZERO);
      push_op(MODE_INS_REAR, WORD_ONES);
      push_op(MODE_RD_FRONT, WORD_ZERO);
      push_op(MODE_RD_REAR, WORD_ZERO);
      push_op(MODE_SPARE_7, WORD_ZERO);
      push_op(MODE_DEL_FRONT, WORD_ZERO);
      push_op(MODE_RD_FRONT, WORD_ZERO);
      push_op(MODE_DEL_REAR, WORD_ZERO);
      push_op(MODE_RD_REAR, WORD_ZERO);
      push_op(MODE_DEL_FRONT, WORD_ZERO);
      push_op(MODE_DEL_REAR, WORD_ZERO);
      push_op(MODE_DEL_REAR, WORD_ZERO);
      wait_drained();

      // A zero capacity saturates to a single slot.
      set_idling(1);
      write_capacity(11'd0);
      push_op(MODE_INS_REAR, 32'h1234_5678);
      push_op(MODE_INS_FRONT, 32'h0bad_f00d);
      push_op(MODE_RD_FRONT, WORD_ZERO);
      push_op(MODE_RD_REAR, WORD_ZERO);
      push_op(MODE_DEL_FRONT, WORD_ZERO);
      push_op(MODE_DEL_FRONT, WORD_ZERO);
      push_op(MODE_INS_FRONT, WORD_MIN);
      push_op(MODE_RD_REAR, WORD_ZERO);
      push_op(MODE_DEL_REAR, WORD_ZERO);
      wait_drained();

      // Full depth: fill past the top, read both ends, then take a few words off each end.
      set_idling(0);
      write_capacity(11'd1024);
      for (int k = 0; k <= DEPTH_DEFAULT; k++)
         push_op(k[0] ? MODE_INS_REAR : MODE_INS_FRONT, pick_word());
      push_op(MODE_RD_FRONT, WORD_ZERO);
      push_op(MODE_RD_REAR, WORD_ZERO);
      for (int k = 0; k < 4; k++)
         push_op(k[0] ? MODE_DEL_FRONT : MODE_DEL_REAR, WORD_ZERO);
      push_op(MODE_RD_FRONT, WORD_ZERO);
      push_op(MODE_RD_REAR, WORD_ZERO);
      wait_drained();

      // Random phases over a spread of capacities, small ones most often.
      for (int p = 0; p < 16; p++) begin
         case (p)
            0:       cap_value = 11'd2047;
            1:       cap_value = 11'd1;
            2:       cap_value = 11'd2;
            3:       cap_value = 11'd1025;
            4:       cap_value = 11'd3;
            5:       cap_value = 11'd0;
            6:       cap_value = 11'd5;
            7:       cap_value = CNT_W'($urandom_range(2047, 1));
            default: cap_value = CNT_W'($urandom_range(48, 1));
         endcase
         set_idling(p);
         write_capacity(cap_value);
         queue_random_ops(60);
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (pending_answers.size() != 0)
         flag_mismatch("answers never returned", DATA_W'(pending_answers.size()), '0);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #7_200_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
